[rtl/core/fpa_pkg.sv]
// shared constants, codes and types of the fixed page allocator
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

  localparam int MAX_PAGES  = 256;
  localparam int ADDR_WIDTH = 48;

  localparam int PS_W      = 32;
  localparam int PC_W      = 9;
  localparam int CNT_W     = $clog2(MAX_PAGES + 1);
  localparam int IDX_W     = $clog2(MAX_PAGES);
  localparam int STEP_W    = $clog2(CNT_W);
  localparam int CHUNK     = 8;
  localparam int CHUNK_W   = 3;
  localparam int CHUNKS    = (MAX_PAGES + CHUNK - 1) / CHUNK;
  localparam int SCAN_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int MAP_W     = CHUNKS * CHUNK;
  localparam int UNIT_W    = (ADDR_WIDTH > PS_W + CNT_W) ? ADDR_WIDTH : PS_W + CNT_W;
  localparam int CFG_W     = (ADDR_WIDTH > PS_W) ? ADDR_WIDTH : PS_W;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = ((PS_W + ADDR_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ADDR_WIDTH + 7) / 8) * 8;

  localparam logic [PS_W-1:0] PAGE_SIZE_RESET  = 32'd4096;
  localparam logic [PC_W-1:0] PAGE_COUNT_RESET = 9'd256;

  // request kinds, anything other than allocate or free is a query
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
  localparam logic [1:0] STATUS_NO_FREE   = 2'd2;
  localparam logic [1:0] STATUS_NOT_OWNED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE       = 2'd2;

  typedef struct packed {
    logic              clr;
    logic              set;
    logic [IDX_W-1:0]  idx;
    logic [SCAN_W-1:0] chunk;
  } map_ctl_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] pos;
  } map_scan_t;

endpackage

`default_nettype wire

[rtl/core/fpa_alu.sv]
// shared add and subtract unit with borrow out
`timescale 1ns / 1ps
`default_nettype none

module fpa_alu import fpa_pkg::*; (
  input  wire logic [UNIT_W-1:0] a,
  input  wire logic [UNIT_W-1:0] b,
  input  wire logic              sub,
  output logic      [UNIT_W-1:0] y,
  output logic                   borrow
);

  logic [UNIT_W:0] sum;

  always_comb begin
    sum    = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (UNIT_W + 1)'(sub);
    y      = sum[UNIT_W-1:0];
    borrow = sub & ~sum[UNIT_W];
  end

endmodule

`default_nettype wire

[rtl/core/fpa_free_map.sv]
// free marks of all pages with an eight page chunk scanner
`timescale 1ns / 1ps
`default_nettype none

module fpa_free_map import fpa_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire map_ctl_t         ctl,
  input  wire logic [CNT_W-1:0] pages,
  output map_scan_t             scan
);

  logic [MAP_W-1:0] marks;

  // clr takes the lowest free page of the chunk when there is one
  always_ff @(posedge clk) begin
    if (rst) begin
      marks <= '1;
    end else begin
      if (ctl.clr && scan.found) begin
        marks[scan.pos] <= 1'b0;
      end
      if (ctl.set) begin
        marks[ctl.idx] <= 1'b1;
      end
    end
  end

  // lowest free page of the chunk that lies below the page count
  always_comb begin
    logic [CHUNK-1:0] bits;
    logic [31:0]      first;
    bits  = marks[ctl.chunk * CHUNK +: CHUNK];
    first = 32'(ctl.chunk) * CHUNK;
    scan  = '0;
    for (int j = CHUNK - 1; j >= 0; j--) begin
      if (bits[j] && (first + 32'(j) < 32'(pages))) begin
        scan.found = 1'b1;
        scan.pos   = IDX_W'(first + 32'(j));
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/fixed_page_allocator.sv]
// fixed page allocator top level: registers, sequencer and stream ports
//
// A pool of page_count equal pages (at most MAX_PAGES) of the configured page
// size starting at base_address. One request is worked on at a time;
// s_axis_tready is high only while the sequencer is idle, and a finished result
// waits in the output register without holding up the next request. All
// address and size arithmetic runs through one shared add/subtract unit. An
// allocate does the size check, scans the free marks eight pages a cycle, runs
// a shift-add multiply and adds the base; a size failure ends after the size
// check and a full pool after the last chunk is scanned. A free or query forms
// the offset, runs a shift-add multiply for the pool span, the range compare, a
// restoring division and the alignment check, or ends after the range compare
// when the address lies outside the pool. The result is then handed over, held
// back while the previous result still sits unread in the output register, and
// the sequencer goes idle to take the next request.
// Configuration writes are always taken and must only be issued while no
// request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module fixed_page_allocator import fpa_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // request_size, address
  input  wire logic [1:0]            s_axis_tuser,   // mode
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // page_address
  output logic [2:0]                 m_axis_tuser,   // status, owned
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SIZE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_BASE  = 4'd4;
  localparam logic [3:0] S_OFF   = 4'd5;
  localparam logic [3:0] S_SPAN  = 4'd6;
  localparam logic [3:0] S_RANGE = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_OWN   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]            state;
  logic [PS_W-1:0]       pg_bytes;
  logic [PC_W-1:0]       page_count;
  logic [ADDR_WIDTH-1:0] base_address;

  logic [1:0]            mode;
  logic [PS_W-1:0]       request_size;
  logic [ADDR_WIDTH-1:0] address;

  logic [UNIT_W-1:0]     acc;
  logic [UNIT_W-1:0]     rem;
  logic [UNIT_W-1:0]     dvs;
  logic [CNT_W-1:0]      mult;
  logic [IDX_W-1:0]      quo;
  logic [STEP_W-1:0]     step;
  logic [SCAN_W-1:0]     chunk;

  logic [1:0]            res_status;
  logic [ADDR_WIDTH-1:0] res_paddr;
  logic                  res_owned;

  logic                  out_valid;
  logic [1:0]            out_status;
  logic [ADDR_WIDTH-1:0] out_paddr;
  logic                  out_owned;

  logic [CNT_W-1:0]      pages;
  logic                  last_chunk;
  logic                  rem_zero;
  logic [UNIT_W-1:0]     alu_a;
  logic [UNIT_W-1:0]     alu_b;
  logic                  alu_sub;
  logic [UNIT_W-1:0]     alu_y;
  logic                  alu_borrow;
  map_ctl_t              map_ctl;
  map_scan_t             map_scan;

  assign pages = (32'(page_count) > 32'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : CNT_W'(page_count);
  assign last_chunk = (32'(chunk) * CHUNK + CHUNK >= 32'(pages)) ||
                      (chunk == SCAN_W'(CHUNKS - 1));
  assign rem_zero = (rem == '0);

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'(out_paddr);
  assign m_axis_tuser  = {out_owned, out_status};
  assign cfg_ready     = 1'b1;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_SIZE: begin
        alu_a   = UNIT_W'(pg_bytes);
        alu_b   = UNIT_W'(request_size);
        alu_sub = 1'b1;
      end
      S_MUL, S_SPAN: begin
        alu_a = acc << 1;
        alu_b = mult[CNT_W-1] ? UNIT_W'(pg_bytes) : '0;
      end
      S_BASE: begin
        alu_a = acc;
        alu_b = UNIT_W'(base_address);
      end
      S_OFF: begin
        alu_a   = UNIT_W'(address);
        alu_b   = UNIT_W'(base_address);
        alu_sub = 1'b1;
      end
      S_RANGE: begin
        alu_a   = rem;
        alu_b   = acc;
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = rem;
        alu_b   = dvs;
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    map_ctl.clr   = (state == S_SCAN);
    map_ctl.set   = (state == S_OWN) && rem_zero && (mode == MODE_FREE);
    map_ctl.idx   = quo;
    map_ctl.chunk = chunk;
  end

  fpa_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .y      (alu_y),
    .borrow (alu_borrow)
  );

  fpa_free_map u_free_map (
    .clk   (clk),
    .rst   (rst),
    .ctl   (map_ctl),
    .pages (pages),
    .scan  (map_scan)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      pg_bytes     <= PAGE_SIZE_RESET;
      page_count   <= PAGE_COUNT_RESET;
      base_address <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PAGE_SIZE:  pg_bytes     <= cfg_data[PS_W-1:0];
          CFG_PAGE_COUNT: page_count   <= cfg_data[PC_W-1:0];
          CFG_BASE:       base_address <= cfg_data[ADDR_WIDTH-1:0];
          default: ;
        endcase
      end
      if (m_axis_tready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            mode         <= s_axis_tuser;
            request_size <= s_axis_tdata[PS_W-1:0];
            address      <= s_axis_tdata[PS_W +: ADDR_WIDTH];
            res_status   <= STATUS_OK;
            res_paddr    <= '0;
            res_owned    <= 1'b0;
            state        <= (s_axis_tuser == MODE_ALLOC) ? S_SIZE : S_OFF;
          end
        end
        S_SIZE: begin
          if (alu_borrow) begin
            res_status <= STATUS_TOO_LARGE;
            state      <= S_DONE;
          end else begin
            chunk <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (map_scan.found) begin
            mult  <= CNT_W'(map_scan.pos);
            acc   <= '0;
            step  <= STEP_W'(CNT_W - 1);
            state <= S_MUL;
          end else if (last_chunk) begin
            res_status <= STATUS_NO_FREE;
            state      <= S_DONE;
          end else begin
            chunk <= chunk + 1'b1;
          end
        end
        S_MUL, S_SPAN: begin
          acc  <= alu_y;
          mult <= mult << 1;
          step <= step - 1'b1;
          if (step == '0) begin
            state <= (state == S_MUL) ? S_BASE : S_RANGE;
          end
        end
        S_BASE: begin
          res_paddr <= alu_y[ADDR_WIDTH-1:0];
          state     <= S_DONE;
        end
        S_OFF: begin
          rem   <= UNIT_W'(alu_y[ADDR_WIDTH-1:0]);
          acc   <= '0;
          mult  <= pages;
          step  <= STEP_W'(CNT_W - 1);
          state <= S_SPAN;
        end
        S_RANGE: begin
          // offset at or beyond the pool span
          if (!alu_borrow) begin
            res_status <= STATUS_NOT_OWNED;
            state      <= S_DONE;
          end else begin
            dvs   <= UNIT_W'(pg_bytes) << (IDX_W - 1);
            quo   <= '0;
            step  <= STEP_W'(IDX_W - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!alu_borrow) begin
            rem <= alu_y;
          end
          quo  <= IDX_W'({quo, ~alu_borrow});
          dvs  <= dvs >> 1;
          step <= step - 1'b1;
          if (step == '0) begin
            state <= S_OWN;
          end
        end
        S_OWN: begin
          if (rem_zero) begin
            res_owned <= 1'b1;
          end else begin
            res_status <= STATUS_NOT_OWNED;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_paddr  <= res_paddr;
            out_owned  <= res_owned;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while a request is in flight");

  a_no_addr_on_fail: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser[1:0] != STATUS_OK)) |-> (m_axis_tdata == '0))
    else $error("page address given with a failing status");

  a_owned_is_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tuser[1:0] == STATUS_OK))
    else $error("owned result without ok status");

  a_mark_single_op: assert property (@(posedge clk) disable iff (rst)
    !(map_ctl.clr && map_ctl.set))
    else $error("free mark set and cleared together");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |=> (out_valid && $stable(out_paddr)))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

[bench/tb.sv]
// self-checking stream testbench for the fixed page allocator
`timescale 1ns / 1ps

module tb;
  import fpa_pkg::*;

  localparam logic [1:0] MODE_QUERY     = 2'd2;
  localparam logic [1:0] MODE_QUERY_ALT = 2'd3;
  localparam int HOLD_CYCLES = 800;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [1:0]            mode;
    logic [PS_W-1:0]       size;
    logic [ADDR_WIDTH-1:0] address;
  } request_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [ADDR_WIDTH-1:0] page_address;
    logic                  owned;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;   // request_size, address
  logic [1:0]           s_axis_tuser = '0;   // mode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;       // page_address
  logic [2:0]            m_axis_tuser;       // status, owned
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // pool settings and free marks as the block should hold them
  logic [PS_W-1:0]       cfg_pg_bytes = PAGE_SIZE_RESET;
  logic [PC_W-1:0]       cfg_count = PAGE_COUNT_RESET;
  logic [ADDR_WIDTH-1:0] cfg_base = '0;
  logic                  page_free [MAX_PAGES] = '{default: 1'b1};

  request_t request_backlog[$];
  reply_t   predicted_replies[$];
  request_t tx_req;
  int queued_count = 0;
  int accepted_count = 0;
  int mismatches = 0;
  int settings_used = 0;
  int n_granted = 0, n_no_free = 0, n_too_large = 0, n_owned = 0, n_not_owned = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  logic tx_burst = 1'b0;
  logic rx_burst = 1'b0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;

  fixed_page_allocator dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [ADDR_WIDTH-1:0] page_addr(input int unsigned idx);
    return cfg_base + ADDR_WIDTH'(64'(idx) * 64'(cfg_pg_bytes));
  endfunction

  function automatic reply_t serve_request(input request_t req);
    reply_t res;
    logic [63:0] pages;
    logic [63:0] span;
    logic [ADDR_WIDTH-1:0] offset;
    logic found;
    res = '0;
    pages = (cfg_count > MAX_PAGES) ? 64'(MAX_PAGES) : 64'(cfg_count);
    if (req.mode == MODE_ALLOC) begin
      if (req.size > cfg_pg_bytes) begin
        res.status = STATUS_TOO_LARGE;
        n_too_large++;
      end else begin
        found = 1'b0;
        for (int i = 0; i < MAX_PAGES; i++) begin
          if (!found && i < pages && page_free[i]) begin
            page_free[i] = 1'b0;
            res.page_address = page_addr(i);
            found = 1'b1;
          end
        end
        res.status = found ? STATUS_OK : STATUS_NO_FREE;
        if (found) n_granted++;
        else n_no_free++;
      end
    end else begin
      // offset wraps at the address width
      offset = req.address - cfg_base;
      span = pages * 64'(cfg_pg_bytes);
      if (cfg_pg_bytes != 0 && 64'(offset) < span && offset % cfg_pg_bytes == 0) begin
        res.owned = 1'b1;
        n_owned++;
        if (req.mode == MODE_FREE) page_free[offset / cfg_pg_bytes] = 1'b1;
      end else begin
        res.status = STATUS_NOT_OWNED;
        n_not_owned++;
      end
    end
    return res;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int unsigned pick;
    int unsigned pages;
    pages = (cfg_count > MAX_PAGES) ? MAX_PAGES : cfg_count;
    pick = $urandom_range(0, 99);
    r.mode = MODE_ALLOC;
    r.size = $urandom;
    r.address = ADDR_WIDTH'({$urandom, $urandom});
    if (pick < 42) begin
      r.size = ($urandom_range(0, 3) == 0) ? cfg_pg_bytes : $urandom_range(0, cfg_pg_bytes);
    end else if (pick < 85) begin
      if ($urandom_range(0, 2) != 0) r.mode = MODE_FREE;
      else r.mode = $urandom_range(0, 1) ? MODE_QUERY : MODE_QUERY_ALT;
      // one page past the end is included
      r.address = page_addr($urandom_range(0, pages));
      if ($urandom_range(0, 7) == 0) r.address = r.address + $urandom_range(1, 3);
    end else begin
      r.mode = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 1) != 0) r.size = cfg_pg_bytes + 1;
    end
    return r;
  endfunction

  task automatic enqueue_request(input logic [1:0] mode, input logic [PS_W-1:0] size,
                                 input logic [ADDR_WIDTH-1:0] address);
    request_backlog.push_back('{mode: mode, size: size, address: address});
    queued_count++;
  endtask

  task automatic enqueue_random(input int count);
    repeat (count) begin
      request_backlog.push_back(random_request());
      queued_count++;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (accepted_count != queued_count || predicted_replies.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PAGE_SIZE:  cfg_pg_bytes = value[PS_W-1:0];
      CFG_PAGE_COUNT: cfg_count = value[PC_W-1:0];
      CFG_BASE:       cfg_base = value[ADDR_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic set_pool(input logic [PS_W-1:0] size, input logic [PC_W-1:0] count,
                          input logic [ADDR_WIDTH-1:0] base);
    wait_idle();
    write_reg(CFG_PAGE_SIZE, CFG_W'(size));
    write_reg(CFG_PAGE_COUNT, CFG_W'(count));
    write_reg(CFG_BASE, CFG_W'(base));
    settings_used++;
    @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_gap <= 0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_replies.push_back(serve_request(tx_req));
        accepted_count++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
        end else if (request_backlog.size() != 0) begin
          tx_req = request_backlog.pop_front();
          s_axis_tdata <= {tx_req.address, tx_req.size};
          s_axis_tuser <= tx_req.mode;
          offer = 1'b1;
          tx_gap <= tx_burst ? 0 : $urandom_range(0, 9);
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_seen != hold_toggle) begin
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_toggle;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // reply monitor
  always @(posedge clk) begin
    int unsigned pause;
    reply_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait <= 0;
    end else begin
      pause = rx_wait;
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_replies.size() == 0) begin
          $display("%0t: unexpected reply, status %0d page_address %h owned %0d", $time,
                   m_axis_tuser[1:0], m_axis_tdata, m_axis_tuser[2]);
          mismatches++;
        end else begin
          want = predicted_replies.pop_front();
          if (m_axis_tuser[1:0] !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d", $time,
                     want.status, m_axis_tuser[1:0]);
            mismatches++;
          end
          if (m_axis_tdata[ADDR_WIDTH-1:0] !== want.page_address) begin
            $display("%0t: page_address mismatch, expected %h, got %h", $time,
                     want.page_address, m_axis_tdata[ADDR_WIDTH-1:0]);
            mismatches++;
          end
          if (m_axis_tuser[2] !== want.owned) begin
            $display("%0t: owned mismatch, expected %0d, got %0d", $time,
                     want.owned, m_axis_tuser[2]);
            mismatches++;
          end
        end
        pause = rx_burst ? 0 : $urandom_range(0, 9);
      end
      if (pause != 0) begin
        m_axis_tready <= 1'b0;
        rx_wait <= pause - 1;
      end else begin
        m_axis_tready <= (hold_left == 0);
        rx_wait <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset pool: size limits, alignment, range, double free
    enqueue_request(MODE_ALLOC, 32'd0, '0);
    enqueue_request(MODE_ALLOC, 32'd4096, '1);
    enqueue_request(MODE_ALLOC, 32'd4097, '0);
    enqueue_request(MODE_ALLOC, 32'hFFFF_FFFF, '0);
    enqueue_request(MODE_QUERY, '1, 48'd0);
    enqueue_request(MODE_QUERY, 32'd0, 48'd4097);
    enqueue_request(MODE_QUERY, 32'd0, 48'd256 * 48'd4096);
    enqueue_request(MODE_QUERY_ALT, 32'd0, 48'd4096);
    enqueue_request(MODE_FREE, 32'd0, 48'd4096);
    enqueue_request(MODE_FREE, 32'd0, 48'd4096);
    enqueue_request(MODE_FREE, 32'd0, 48'hFFFF_FFFF_FFFF);
    enqueue_request(MODE_ALLOC, 32'd1, '0);

    // pool near the top of the address space so page addresses wrap
    set_pool(32'd4096, 9'd3, 48'hFFFF_FFFF_F000);
    enqueue_request(MODE_ALLOC, 32'd100, '0);
    enqueue_request(MODE_ALLOC, 32'd100, '0);
    enqueue_request(MODE_FREE, 32'd0, 48'h1000);
    enqueue_request(MODE_QUERY, 32'd0, 48'h2000);
    enqueue_request(MODE_ALLOC, 32'd4096, '0);

    // zero page size
    set_pool(32'd0, 9'd256, 48'h100);
    enqueue_request(MODE_ALLOC, 32'd0, '0);
    enqueue_request(MODE_ALLOC, 32'd1, '0);
    enqueue_request(MODE_QUERY, 32'd0, 48'h100);

    // empty pool
    set_pool(32'd4096, 9'd0, 48'h0);
    enqueue_request(MODE_ALLOC, 32'd0, '0);
    enqueue_request(MODE_QUERY, 32'd0, 48'h0);

    // largest page size, count above the pool capacity
    set_pool(32'hFFFF_FFFF, 9'd511, 48'h0);
    enqueue_request(MODE_ALLOC, 32'hFFFF_FFFF, '0);
    enqueue_request(MODE_QUERY, 32'd0, 48'd255 * 48'hFFFF_FFFF);
    enqueue_request(MODE_FREE, 32'd0, 48'd256 * 48'hFFFF_FFFF);

    // receiver holds off while the sender keeps pushing
    set_pool(32'd64, 9'd16, 48'h1000);
    tx_burst = 1'b1;
    hold_toggle = ~hold_toggle;
    enqueue_random(100);

    set_pool(32'hFFFF_FFFF, 9'd256, 48'hFFFF_0000_0000);
    tx_burst = 1'b0;
    enqueue_random(80);

    set_pool(32'd1, 9'd1, 48'hFFFF_FFFF_FFFF);
    enqueue_random(60);

    set_pool(32'd48, 9'd300, ADDR_WIDTH'({$urandom, $urandom}));
    enqueue_random(80);

    set_pool($urandom_range(1, 32'h10_0000), PC_W'($urandom_range(1, 8)),
             ADDR_WIDTH'({$urandom, $urandom}));
    rx_burst = 1'b1;
    enqueue_random(100);

    set_pool(32'd4096, 9'd0, 48'h0);
    rx_burst = 1'b0;
    enqueue_random(30);

    set_pool(PS_W'($urandom), 9'd2, ADDR_WIDTH'({$urandom, $urandom}));
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    enqueue_random(50);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("%0d requests over %0d pool settings: %0d pages granted, %0d pool empty, %0d oversize",
             accepted_count, settings_used, n_granted, n_no_free, n_too_large);
    $display("frees and queries: %0d on owned pages, %0d on foreign addresses",
             n_owned, n_not_owned);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/fpa_pkg.sv
rtl/core/fpa_alu.sv
rtl/core/fpa_free_map.sv
rtl/core/fixed_page_allocator.sv
bench/tb.sv
